[design/hex_text_codec_assert.svh]
// assertion macros for the hex text codec
// used by the front, queue and back modules; expects clk and rst in scope
`ifndef HEX_TEXT_CODEC_ASSERT_SVH
`define HEX_TEXT_CODEC_ASSERT_SVH
`ifndef SYNTHESIS
`define HXC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define HXC_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define HXC_ASSERT(name, prop, msg)
`define HXC_NEVER(name, cond, msg)
`endif
`endif

[design/hxc_pkg.sv]
// shared types, codes and character helpers for the hex text codec
// no dependencies; imported by every module of the block
package hxc_pkg;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [2:0] FMT_PLAIN = 3'd0;
  localparam logic [2:0] FMT_MIXED = 3'd1;
  localparam logic [2:0] FMT_ESC   = 3'd2;
  localparam logic [2:0] FMT_CARR  = 3'd3;
  localparam logic [2:0] FMT_CSV   = 3'd4;

  localparam logic [1:0] REG_DIRECTION  = 2'd0;
  localparam logic [1:0] REG_FORMAT     = 2'd1;
  localparam logic [1:0] REG_ADD_PREFIX = 2'd2;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7e;

  localparam int MAX_CHARS = 8;

  // the output characters of one request, data[0] goes out first
  typedef struct packed {
    logic [3:0]                cnt;
    logic [MAX_CHARS-1:0][7:0] data;
  } desc_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  function automatic desc_t put_char(desc_t d, logic [7:0] c);
    desc_t r;
    r = d;
    r.data[r.cnt[2:0]] = c;
    r.cnt = r.cnt + 4'd1;
    return r;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] nib);
    logic [7:0] r;
    if (nib < 4'd10) r = CH_ZERO + {4'b0000, nib};
    else             r = 8'h57 + {4'b0000, nib};
    return r;
  endfunction

  // {valid, value} of one hex digit character
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    else r = 5'b00000;
    return r;
  endfunction

endpackage

[design/hex_text_codec.sv]
// Hex text codec. Each input byte (in_byte on s_tdata, in_last on s_tlast) is
// turned into lower-case hex text, or in decode direction text is turned back
// into bytes, in the format chosen by the direction, format and add_prefix
// registers. An item produces zero to eight result characters; results leave
// one per clock while m_tready accepts them through a registered output, and
// the last result of an item carries m_tlast. The front end takes one item per
// cycle while the request queue (QUEUE_DEPTH entries) has room; the
// single-character output shifter bounds throughput: a C array byte that both
// opens and closes a message gives eight characters, other C array bytes six
// or seven, escaped four, plain hex two (four with the prefix on the first
// byte of a message). An item passes the queue, shifter and output registers;
// items that produce nothing push no request. Configure only while idle.
module hex_text_codec import hxc_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_data,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast
);

  q_stat_t q_stat;
  logic    push;
  desc_t   push_desc;
  logic    pop;
  desc_t   head;

  hxc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_byte   (s_tdata),
    .in_last   (s_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_desc (push_desc)
  );

  hxc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  hxc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .head      (head),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

[design/hxc_front.sv]
// front end: config registers, decode window state, builds the character list per request
// depends on hxc_pkg and hex_text_codec_assert.svh
`include "hex_text_codec_assert.svh"
module hxc_front import hxc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [2:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  q_stat_t    q_stat,
  output logic       push,
  output desc_t      push_desc
);

  logic       dir;
  logic [2:0] fmt;
  logic       add_prefix;
  logic       at_start;

  logic [2:0][7:0] pend;
  logic [2:0][7:0] pend_next;
  logic [1:0]      pcnt;
  logic [1:0]      pcnt_next;

  logic [3:0][7:0] win;
  logic [2:0]      wcnt;
  logic            mixed;
  logic            dec_on;
  logic [7:0]      lead;
  logic [4:0]      hv_hi;
  logic [4:0]      hv_lo;
  logic            match;
  logic            fire;
  desc_t           d;

  assign in_ready = !q_stat.full;
  assign fire     = in_valid && in_ready;

  always_comb begin
    win       = {8'h00, pend};
    win[pcnt] = in_byte;
    wcnt      = {1'b0, pcnt} + 3'd1;
  end

  assign mixed  = (fmt == FMT_MIXED);
  assign dec_on = (fmt == FMT_MIXED) || (fmt == FMT_ESC) || (fmt == FMT_CARR);
  assign lead   = (fmt == FMT_CARR) ? CH_ZERO : CH_BSLASH;
  assign hv_hi  = hex_val(win[2]);
  assign hv_lo  = hex_val(win[3]);
  assign match  = (win[0] == lead) && (win[1] == CH_X) && hv_hi[4] && hv_lo[4];

  always_comb begin
    d         = '0;
    pend_next = pend;
    pcnt_next = pcnt;
    if (dir == DIR_ENCODE) begin
      unique case (fmt)
        FMT_PLAIN: begin
          if (at_start && add_prefix) begin
            d = put_char(d, CH_ZERO);
            d = put_char(d, CH_X);
          end
          d = put_char(d, hex_char(in_byte[7:4]));
          d = put_char(d, hex_char(in_byte[3:0]));
        end
        FMT_MIXED: begin
          if (in_byte < PRINT_LO || in_byte > PRINT_HI) begin
            d = put_char(d, CH_BSLASH);
            d = put_char(d, CH_X);
            d = put_char(d, hex_char(in_byte[7:4]));
            d = put_char(d, hex_char(in_byte[3:0]));
          end else begin
            d = put_char(d, in_byte);
          end
        end
        FMT_ESC: begin
          d = put_char(d, CH_BSLASH);
          d = put_char(d, CH_X);
          d = put_char(d, hex_char(in_byte[7:4]));
          d = put_char(d, hex_char(in_byte[3:0]));
        end
        FMT_CARR: begin
          if (at_start) d = put_char(d, CH_LBRACE);
          d = put_char(d, CH_SPACE);
          d = put_char(d, CH_ZERO);
          d = put_char(d, CH_X);
          d = put_char(d, hex_char(in_byte[7:4]));
          d = put_char(d, hex_char(in_byte[3:0]));
          if (in_last) begin
            d = put_char(d, CH_SPACE);
            d = put_char(d, CH_RBRACE);
          end else begin
            d = put_char(d, CH_COMMA);
          end
        end
        FMT_CSV: begin
          d = put_char(d, hex_char(in_byte[7:4]));
          d = put_char(d, hex_char(in_byte[3:0]));
          d = put_char(d, CH_COMMA);
        end
        default: begin
        end
      endcase
    end else if (dec_on) begin
      if (wcnt == 3'd4) begin
        if (match) begin
          d         = put_char(d, {hv_hi[3:0], hv_lo[3:0]});
          pcnt_next = 2'd0;
        end else begin
          // oldest character cannot start a sequence, drop or pass it
          if (mixed) d = put_char(d, win[0]);
          if (in_last) begin
            if (mixed) begin
              d = put_char(d, win[1]);
              d = put_char(d, win[2]);
              d = put_char(d, win[3]);
            end
            pcnt_next = 2'd0;
          end else begin
            pend_next = win[3:1];
            pcnt_next = 2'd3;
          end
        end
      end else if (in_last) begin
        // short window at end of message never matches
        for (int i = 0; i < 3; i++) begin
          if (mixed && 3'(i) < wcnt) d = put_char(d, win[i]);
        end
        pcnt_next = 2'd0;
      end else begin
        pend_next = win[2:0];
        pcnt_next = wcnt[1:0];
      end
    end
    if (in_last) pcnt_next = 2'd0;
  end

  assign push      = fire && (d.cnt != 4'd0);
  assign push_desc = d;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir        <= DIR_ENCODE;
      fmt        <= FMT_PLAIN;
      add_prefix <= 1'b0;
      pcnt       <= 2'd0;
      at_start   <= 1'b1;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_DIRECTION:  dir        <= cfg_data[0];
          REG_FORMAT:     fmt        <= cfg_data;
          REG_ADD_PREFIX: add_prefix <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (fire) begin
        pcnt     <= pcnt_next;
        at_start <= in_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) pend <= pend_next;
  end

  `HXC_ASSERT(a_last_clears_window, fire && in_last |=> pcnt == 2'd0, "window not flushed")
  `HXC_ASSERT(a_last_sets_start, fire && in_last |=> at_start, "start flag not set")
  `HXC_NEVER(a_push_when_full, push && q_stat.full, "push into full queue")

endmodule

[design/hxc_queue.sv]
// short request queue between front and back end
// depends on hxc_pkg and hex_text_codec_assert.svh
`include "hex_text_codec_assert.svh"
module hxc_queue import hxc_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  desc_t   push_desc,
  input  logic    pop,
  output desc_t   head,
  output q_stat_t stat
);

  localparam int IDXW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  desc_t            mem [DEPTH];
  logic [IDXW-1:0]  wr_ptr;
  logic [IDXW-1:0]  rd_ptr;
  logic [CNTW-1:0]  count;

  function automatic logic [IDXW-1:0] bump(logic [IDXW-1:0] p);
    logic [IDXW-1:0] r;
    if (p == IDXW'(DEPTH - 1)) r = '0;
    else                       r = p + IDXW'(1);
    return r;
  endfunction

  assign stat.valid = (count != '0);
  assign stat.full  = (count == CNTW'(DEPTH));
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= bump(wr_ptr);
      if (pop)  rd_ptr <= bump(rd_ptr);
      if (push && !pop)      count <= count + CNTW'(1);
      else if (pop && !push) count <= count - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_desc;
  end

  `HXC_NEVER(a_pop_empty, pop && !stat.valid, "pop from empty queue")

endmodule

[design/hxc_back.sv]
// back end: one char per cycle into the output register unless stalled
// depends on hxc_pkg and hex_text_codec_assert.svh
`include "hex_text_codec_assert.svh"
module hxc_back import hxc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  q_stat_t    q_stat,
  input  desc_t      head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic                      cur_valid;
  logic [MAX_CHARS-1:0][7:0] cur_data;
  logic [3:0]                cur_rem;
  logic                      out_load;
  logic                      cur_done;

  assign out_load = !out_valid || out_ready;
  assign cur_done = cur_valid && out_load && (cur_rem == 4'd1);
  // refill in the same cycle the last character leaves, so no bubble
  assign pop      = q_stat.valid && (!cur_valid || cur_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= cur_valid;
      if (pop)           cur_valid <= 1'b1;
      else if (cur_done) cur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && cur_valid) begin
      out_byte <= cur_data[0];
      out_last <= (cur_rem == 4'd1);
    end
    if (pop) begin
      cur_data <= head.data;
      cur_rem  <= head.cnt;
    end else if (cur_valid && out_load) begin
      cur_data <= cur_data >> 8;
      cur_rem  <= cur_rem - 4'd1;
    end
  end

  `HXC_ASSERT(a_cur_nonempty, cur_valid |-> cur_rem != 4'd0, "active request with no chars")
  `HXC_ASSERT(a_pop_nonempty, pop |-> head.cnt != 4'd0, "empty request in queue")

endmodule
